/* design/contour_cell_segment_extract_core_macros.svh */
// assertion helpers shared by the contour cell core
`ifndef CONTOUR_CELL_SEGMENT_EXTRACT_CORE_MACROS_SVH
`define CONTOUR_CELL_SEGMENT_EXTRACT_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CCSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("contour cell core: assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define CCSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("contour cell core: assertion failed");

`endif

/* design/ccse_pkg.sv */
// ----------------------------------------------------------------------------
// ccse_pkg
// Shared types, register indexes and point pairing helpers of the contour
// cell segment extraction core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccse_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SIZE     = 1'b0,
    REG_HEIGHT_OFFSET = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PAIR_01,
    PAIR_02,
    PAIR_03,
    PAIR_12,
    PAIR_13,
    PAIR_23
  } pair_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [11:0]        cx;
    logic [11:0]        cz;
    logic signed [23:0] lvl;
    logic [3:0]         ev;
  } side_t;

  function automatic logic [1:0] pair_lo(pair_e p);
    logic [1:0] r;
    unique case (p)
      PAIR_01, PAIR_02, PAIR_03: r = 2'd0;
      PAIR_12, PAIR_13:          r = 2'd1;
      PAIR_23:                   r = 2'd2;
      default:                   r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_hi(pair_e p);
    logic [1:0] r;
    unique case (p)
      PAIR_01:                   r = 2'd1;
      PAIR_02, PAIR_12:          r = 2'd2;
      PAIR_03, PAIR_13, PAIR_23: r = 2'd3;
      default:                   r = 2'd1;
    endcase
    return r;
  endfunction

  // the two points left over once a pair is taken
  function automatic pair_e pair_other(pair_e p);
    pair_e r;
    unique case (p)
      PAIR_01: r = PAIR_23;
      PAIR_02: r = PAIR_13;
      PAIR_03: r = PAIR_12;
      PAIR_12: r = PAIR_03;
      PAIR_13: r = PAIR_02;
      PAIR_23: r = PAIR_01;
      default: r = PAIR_23;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ccse_div.sv */
// ----------------------------------------------------------------------------
// ccse_div
// Pipelined restoring divider for one cell edge: rounded crossing fraction
// ((n << FRAC_BITS) + d/2) / d, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccse_div import ccse_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [23:0]          n_i,
  input  wire logic [23:0]          d_i,
  output logic      [FRAC_BITS:0]   q_o
);

  localparam int unsigned S  = FRAC_BITS + 1;
  localparam int unsigned NW = 25 + FRAC_BITS;

  logic [NW-1:0] num;
  logic [23:0]   rem_q [S+1];
  logic [S-1:0]  low_q [S+1];
  logic [23:0]   d_q   [S+1];
  logic [S-1:0]  q_q   [S+1];

  assign num = {1'b0, n_i, {FRAC_BITS{1'b0}}} + NW'(d_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num[NW-1 -: 24];
      low_q[0] <= num[S-1:0];
      d_q[0]   <= d_i;
      q_q[0]   <= '0;
    end
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [24:0] trial;
    logic        ge;
    assign trial = {rem_q[s], low_q[s][S-1]};
    assign ge    = trial >= {1'b0, d_q[s]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? 24'(trial - {1'b0, d_q[s]}) : trial[23:0];
        low_q[s+1] <= {low_q[s][S-2:0], 1'b0};
        d_q[s+1]   <= d_q[s];
        q_q[s+1]   <= {q_q[s][S-2:0], ge};
      end
    end
  end

  assign q_o = q_q[S];

endmodule

`default_nettype wire

/* design/ccse_front.sv */
// ----------------------------------------------------------------------------
// ccse_front
// Front end: takes cell requests, rejects cells off the grid or off the
// level range, flags crossed edges and runs a divider on each cell edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccse_front import ccse_pkg::*; #(
  parameter int unsigned GRID_CELLS = 4096,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ITEM_W     = 52 + 4 * (FRAC_BITS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                start_i,
  input  wire logic [11:0]         cell_x_i,
  input  wire logic [11:0]         cell_z_i,
  input  wire logic signed [23:0]  height_nw_i,
  input  wire logic signed [23:0]  height_ne_i,
  input  wire logic signed [23:0]  height_sw_i,
  input  wire logic signed [23:0]  height_se_i,
  input  wire logic signed [23:0]  contour_level_i,
  output logic                     push_o,
  output logic [ITEM_W-1:0]        item_o
);

  localparam int unsigned LAT = FRAC_BITS + 2;
  localparam int unsigned TW  = FRAC_BITS + 1;

  logic               s1_vld_q;
  logic [11:0]        s1_cx_q, s1_cz_q;
  logic signed [23:0] s1_nw_q, s1_ne_q, s1_sw_q, s1_se_q, s1_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && start_i) begin
      s1_cx_q  <= cell_x_i;
      s1_cz_q  <= cell_z_i;
      s1_nw_q  <= height_nw_i;
      s1_ne_q  <= height_ne_i;
      s1_sw_q  <= height_sw_i;
      s1_se_q  <= height_se_i;
      s1_lvl_q <= contour_level_i;
    end
  end

  // classify the cell
  logic               in_grid, any_le, any_ge, keep;
  logic signed [23:0] h_a [4];
  logic signed [23:0] h_b [4];
  logic [3:0]         ev;
  logic [23:0]        n_e [4];
  logic [23:0]        d_e [4];
  logic [TW-1:0]      q_e [4];

  assign in_grid = ({5'b0, s1_cx_q} < 17'(GRID_CELLS)) && ({5'b0, s1_cz_q} < 17'(GRID_CELLS));
  assign any_le  = (s1_nw_q <= s1_lvl_q) || (s1_ne_q <= s1_lvl_q) ||
                   (s1_sw_q <= s1_lvl_q) || (s1_se_q <= s1_lvl_q);
  assign any_ge  = (s1_nw_q >= s1_lvl_q) || (s1_ne_q >= s1_lvl_q) ||
                   (s1_sw_q >= s1_lvl_q) || (s1_se_q >= s1_lvl_q);
  assign keep    = s1_vld_q && in_grid && any_le && any_ge;

  // top, right, bottom, left
  assign h_a[0] = s1_nw_q;  assign h_b[0] = s1_ne_q;
  assign h_a[1] = s1_ne_q;  assign h_b[1] = s1_se_q;
  assign h_a[2] = s1_se_q;  assign h_b[2] = s1_sw_q;
  assign h_a[3] = s1_sw_q;  assign h_b[3] = s1_nw_q;

  for (genvar e = 0; e < 4; e++) begin : g_edge
    logic a_le, a_ge, b_le, b_ge;
    assign a_le  = h_a[e] <= s1_lvl_q;
    assign a_ge  = h_a[e] >= s1_lvl_q;
    assign b_le  = h_b[e] <= s1_lvl_q;
    assign b_ge  = h_b[e] >= s1_lvl_q;
    assign ev[e] = ((a_le && b_ge) || (a_ge && b_le)) && (h_a[e] != h_b[e]);
    assign n_e[e] = !a_le ? 24'(25'(h_a[e]) - 25'(s1_lvl_q)) :
                            24'(25'(s1_lvl_q) - 25'(h_a[e]));
    assign d_e[e] = (h_b[e] > h_a[e]) ? 24'(25'(h_b[e]) - 25'(h_a[e])) :
                                        24'(25'(h_a[e]) - 25'(h_b[e]));

    ccse_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .n_i   (n_e[e]),
      .d_i   (d_e[e]),
      .q_o   (q_e[e])
    );
  end

  // side data travels beside the dividers
  logic  vld_q  [LAT];
  side_t side_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= keep;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{cx: s1_cx_q, cz: s1_cz_q, lvl: s1_lvl_q, ev: ev};
      for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  assign push_o = vld_q[LAT-1] && en_i;
  assign item_o = {side_q[LAT-1].cx, side_q[LAT-1].cz, side_q[LAT-1].lvl,
                   side_q[LAT-1].ev, q_e[3], q_e[2], q_e[1], q_e[0]};

endmodule

`default_nettype wire

/* design/ccse_queue.sv */
// ----------------------------------------------------------------------------
// ccse_queue
// Short register queue between the front end and the segment back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccse_queue import ccse_pkg::*; #(
  parameter int unsigned WIDTH = 120,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output q_stat_t               stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == CNT_W'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

endmodule

`default_nettype wire

/* design/ccse_back.sv */
// ----------------------------------------------------------------------------
// ccse_back
// Back end: builds crossing points, drops near duplicates, pairs saddle
// points by distance and emits one or two scaled segments per cell of two or four points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "contour_cell_segment_extract_core_macros.svh"

module ccse_back import ccse_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DEDUP_LSB = 65,
  parameter int unsigned ITEM_W    = 52 + 4 * (FRAC_BITS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ITEM_W-1:0]   item_i,
  input  wire q_stat_t             stat_i,
  output logic                     pop_o,
  input  wire logic [7:0]          tile_size_i,
  input  wire logic signed [23:0]  height_offset_i,
  output logic                     seg_valid_o,
  output logic [35:0]              start_x_o,
  output logic [35:0]              start_z_o,
  output logic [35:0]              end_x_o,
  output logic [35:0]              end_z_o,
  output logic signed [24:0]       segment_height_o,
  output logic                     last_segment_o
);

  localparam int unsigned TW = FRAC_BITS + 1;
  localparam int unsigned PW = 13 + FRAC_BITS;
  localparam int unsigned DW = FRAC_BITS + 1;
  localparam int unsigned SW = 2 * DW + 1;

  logic adv, pend_q, pend_d;
  assign adv   = !pend_d;
  assign pop_o = adv && !stat_i.empty;

  // unpack request
  logic [11:0]        u_cx, u_cz;
  logic signed [23:0] u_lvl;
  logic [3:0]         u_ev;
  logic [TW-1:0]      u_t [4];
  logic [PW-1:0]      x0, x1, z0, z1;
  logic [PW-1:0]      rx [4];
  logic [PW-1:0]      rz [4];

  assign u_cx  = item_i[4*TW+40 +: 12];
  assign u_cz  = item_i[4*TW+28 +: 12];
  assign u_lvl = item_i[4*TW+4 +: 24];
  assign u_ev  = item_i[4*TW +: 4];
  for (genvar e = 0; e < 4; e++) begin : g_t
    assign u_t[e] = item_i[e*TW +: TW];
  end

  assign x0 = PW'({u_cx, {FRAC_BITS{1'b0}}});
  assign z0 = PW'({u_cz, {FRAC_BITS{1'b0}}});
  assign x1 = x0 + (PW'(1) << FRAC_BITS);
  assign z1 = z0 + (PW'(1) << FRAC_BITS);

  assign rx[0] = x0 + PW'(u_t[0]);  assign rz[0] = z0;
  assign rx[1] = x1;                assign rz[1] = z0 + PW'(u_t[1]);
  assign rx[2] = x1 - PW'(u_t[2]);  assign rz[2] = z1;
  assign rx[3] = x0;                assign rz[3] = z1 - PW'(u_t[3]);

  // stage a: raw crossing points
  logic               a_vld_q;
  logic [PW-1:0]      a_x_q [4];
  logic [PW-1:0]      a_z_q [4];
  logic [3:0]         a_ev_q;
  logic signed [23:0] a_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= !stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_x_q   <= rx;
      a_z_q   <= rz;
      a_ev_q  <= u_ev;
      a_lvl_q <= u_lvl;
    end
  end

  // duplicate removal and compaction
  logic [3:0]    keep;
  logic [2:0]    cnt;
  logic [PW-1:0] px [4];
  logic [PW-1:0] pz [4];

  always_comb begin
    logic          hit;
    logic [PW-1:0] dx, dz;
    keep = '0;
    cnt  = '0;
    px   = '{default: '0};
    pz   = '{default: '0};
    for (int i = 0; i < 4; i++) begin
      hit = 1'b0;
      for (int j = 0; j < i; j++) begin
        dx = (a_x_q[j] > a_x_q[i]) ? a_x_q[j] - a_x_q[i] : a_x_q[i] - a_x_q[j];
        dz = (a_z_q[j] > a_z_q[i]) ? a_z_q[j] - a_z_q[i] : a_z_q[i] - a_z_q[j];
        if (keep[j] && dx <= PW'(DEDUP_LSB) && dz <= PW'(DEDUP_LSB)) begin
          hit = 1'b1;
        end
      end
      keep[i] = a_ev_q[i] && !hit;
      if (keep[i]) begin
        px[cnt[1:0]] = a_x_q[i];
        pz[cnt[1:0]] = a_z_q[i];
        cnt = cnt + 3'd1;
      end
    end
  end

  // stage b: kept points
  logic               b_vld_q;
  logic [PW-1:0]      b_x_q [4];
  logic [PW-1:0]      b_z_q [4];
  logic [2:0]         b_cnt_q;
  logic signed [23:0] b_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_x_q   <= px;
      b_z_q   <= pz;
      b_cnt_q <= cnt;
      b_lvl_q <= a_lvl_q;
    end
  end

  // stage c: squared distances of the six pairs
  logic [SW-1:0] pair_dsq [6];

  for (genvar k = 0; k < 6; k++) begin : g_dist
    logic [1:0]    lo, hi;
    logic [DW-1:0] dx, dz;
    assign lo = pair_lo(pair_e'(3'(k)));
    assign hi = pair_hi(pair_e'(3'(k)));
    assign dx = (b_x_q[lo] > b_x_q[hi]) ? DW'(b_x_q[lo] - b_x_q[hi]) :
                                          DW'(b_x_q[hi] - b_x_q[lo]);
    assign dz = (b_z_q[lo] > b_z_q[hi]) ? DW'(b_z_q[lo] - b_z_q[hi]) :
                                          DW'(b_z_q[hi] - b_z_q[lo]);
    assign pair_dsq[k] = SW'(dx) * SW'(dx) + SW'(dz) * SW'(dz);
  end

  logic               c_vld_q;
  logic [SW-1:0]      c_dist_q [6];
  logic [PW-1:0]      c_x_q [4];
  logic [PW-1:0]      c_z_q [4];
  logic [2:0]         c_cnt_q;
  logic signed [23:0] c_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_dist_q <= pair_dsq;
      c_x_q    <= b_x_q;
      c_z_q    <= b_z_q;
      c_cnt_q  <= b_cnt_q;
      c_lvl_q  <= b_lvl_q;
    end
  end

  // nearest pair, left wins ties so the first minimum is kept
  pair_e         m0_p, m1_p, m2_p, m3_p, best_p;
  logic [SW-1:0] m0_v, m1_v, m2_v, m3_v;

  assign m0_p   = (c_dist_q[0] <= c_dist_q[1]) ? PAIR_01 : PAIR_02;
  assign m0_v   = (c_dist_q[0] <= c_dist_q[1]) ? c_dist_q[0] : c_dist_q[1];
  assign m1_p   = (c_dist_q[2] <= c_dist_q[3]) ? PAIR_03 : PAIR_12;
  assign m1_v   = (c_dist_q[2] <= c_dist_q[3]) ? c_dist_q[2] : c_dist_q[3];
  assign m2_p   = (c_dist_q[4] <= c_dist_q[5]) ? PAIR_13 : PAIR_23;
  assign m2_v   = (c_dist_q[4] <= c_dist_q[5]) ? c_dist_q[4] : c_dist_q[5];
  assign m3_p   = (m0_v <= m1_v) ? m0_p : m1_p;
  assign m3_v   = (m0_v <= m1_v) ? m0_v : m1_v;
  assign best_p = (m3_v <= m2_v) ? m3_p : m2_p;

  // stage e: chosen pairing
  logic               e_vld_q;
  pair_e              e_pair_q;
  logic [PW-1:0]      e_x_q [4];
  logic [PW-1:0]      e_z_q [4];
  logic [2:0]         e_cnt_q;
  logic signed [23:0] e_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_pair_q <= (c_cnt_q == 3'd4) ? best_p : PAIR_01;
      e_x_q    <= c_x_q;
      e_z_q    <= c_z_q;
      e_cnt_q  <= c_cnt_q;
      e_lvl_q  <= c_lvl_q;
    end
  end

  // segment emit; a saddle cell stalls the pipeline and emits its second segment from pend_q
  logic          two, four, emit;
  pair_e         sel_p;
  logic [1:0]    ia, ib;
  logic [PW+7:0] sx_p, sz_p, ex_p, ez_p;

  assign two    = e_cnt_q == 3'd2;
  assign four   = e_cnt_q == 3'd4;
  assign emit   = pend_q || (e_vld_q && (two || four));
  assign pend_d = !pend_q && e_vld_q && four;
  assign sel_p  = pend_q ? pair_other(e_pair_q) : e_pair_q;
  assign ia     = pair_lo(sel_p);
  assign ib     = pair_hi(sel_p);
  assign sx_p   = (PW+8)'(e_x_q[ia]) * (PW+8)'(tile_size_i);
  assign sz_p   = (PW+8)'(e_z_q[ia]) * (PW+8)'(tile_size_i);
  assign ex_p   = (PW+8)'(e_x_q[ib]) * (PW+8)'(tile_size_i);
  assign ez_p   = (PW+8)'(e_z_q[ib]) * (PW+8)'(tile_size_i);

  logic seg_valid_q, seg_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      seg_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      seg_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      start_x_o        <= 36'(sx_p);
      start_z_o        <= 36'(sz_p);
      end_x_o          <= 36'(ex_p);
      end_z_o          <= 36'(ez_p);
      segment_height_o <= {e_lvl_q[23], e_lvl_q} + {height_offset_i[23], height_offset_i};
      seg_last_q       <= pend_q || !four;
    end
  end

  assign seg_valid_o    = seg_valid_q;
  assign last_segment_o = seg_last_q;

  `CCSE_ASSERT_NEXT(a_pend_once, pend_q, !pend_q)
  `CCSE_ASSERT_NEXT(a_pend_emits_last, pend_q, seg_valid_q && seg_last_q)
  `CCSE_ASSERT_IMPL(a_no_pop_empty, pop_o, !stat_i.empty)

endmodule

`default_nettype wire

/* design/contour_cell_segment_extract_core.sv */
// ----------------------------------------------------------------------------
// contour_cell_segment_extract_core
// Marching squares cell: corner heights and a level in, contour segments out.
//
// Request channel: a cell is taken on a clock edge with start high and busy
// low. busy rises only when the internal queue between the divider front end
// and the segment back end is full.
// Result channel: seg_valid_o marks one segment for one cycle; the receiver
// cannot hold it off. A saddle cell gives two segments on consecutive cycles,
// other crossing cells one, with last_segment_o on the final one. Cells off
// the grid, outside the corner range or with 0, 1 or 3 points give nothing.
// Each cell passes through a divider on each of its edges; the dividers resolve
// one quotient bit per stage.
// Throughput: one cell per cycle while busy is low; a saddle cell holds the
// back end for its second segment on the single result port.
// Config: cfg_we_i with cfg_idx_i 0 for tile size, 1 for height offset, taken
// at once. Write only while no cell is in flight; the core does not check.
// Reset: clears all pipelines and the queue, tile size 16, offset 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module contour_cell_segment_extract_core import ccse_pkg::*; #(
  parameter int unsigned GRID_CELLS = 4096,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DEDUP_LSB  = 65
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0]  cfg_wdata_i,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [11:0]           cell_x_i,
  input  wire logic [11:0]           cell_z_i,
  input  wire logic signed [23:0]    height_nw_i,
  input  wire logic signed [23:0]    height_ne_i,
  input  wire logic signed [23:0]    height_sw_i,
  input  wire logic signed [23:0]    height_se_i,
  input  wire logic signed [23:0]    contour_level_i,
  output logic                       seg_valid_o,
  output logic [35:0]                start_x_o,
  output logic [35:0]                start_z_o,
  output logic [35:0]                end_x_o,
  output logic [35:0]                end_z_o,
  output logic signed [24:0]         segment_height_o,
  output logic                       last_segment_o
);

  localparam int unsigned ITEM_W = 52 + 4 * (FRAC_BITS + 1);
  localparam int unsigned QDEPTH = 4;

  logic [7:0]         tile_size_q;
  logic signed [23:0] height_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q     <= 8'd16;
      height_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TILE_SIZE:     tile_size_q     <= cfg_wdata_i[7:0];
        REG_HEIGHT_OFFSET: height_offset_q <= cfg_wdata_i;
        default:           tile_size_q     <= tile_size_q;
      endcase
    end
  end

  logic              push, pop, en;
  logic [ITEM_W-1:0] push_data, pop_data;
  q_stat_t           q_stat;

  assign en   = !q_stat.full;
  assign busy = q_stat.full;

  ccse_front #(
    .GRID_CELLS (GRID_CELLS),
    .FRAC_BITS  (FRAC_BITS),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .start_i         (start),
    .cell_x_i        (cell_x_i),
    .cell_z_i        (cell_z_i),
    .height_nw_i     (height_nw_i),
    .height_ne_i     (height_ne_i),
    .height_sw_i     (height_sw_i),
    .height_se_i     (height_se_i),
    .contour_level_i (contour_level_i),
    .push_o          (push),
    .item_o          (push_data)
  );

  ccse_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .stat_o (q_stat)
  );

  ccse_back #(
    .FRAC_BITS (FRAC_BITS),
    .DEDUP_LSB (DEDUP_LSB),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (pop_data),
    .stat_i           (q_stat),
    .pop_o            (pop),
    .tile_size_i      (tile_size_q),
    .height_offset_i  (height_offset_q),
    .seg_valid_o      (seg_valid_o),
    .start_x_o        (start_x_o),
    .start_z_o        (start_z_o),
    .end_x_o          (end_x_o),
    .end_z_o          (end_z_o),
    .segment_height_o (segment_height_o),
    .last_segment_o   (last_segment_o)
  );

endmodule

`default_nettype wire

/* dv/contour_cell_segment_extract_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_cell_segment_extract_core_tb
// Drives contour cells through the core, directed corner cases first and then
// random cells under several tile size and height offset settings. Each
// accepted cell is run through a local contour predictor, and every segment
// from the core is compared in order with the predicted segments.
// ----------------------------------------------------------------------------
module contour_cell_segment_extract_core_tb import ccse_pkg::*;;

  localparam int unsigned FRAC = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned DUP_LSB = 65;
  localparam longint unsigned COORD_MASK = 64'hF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [11:0]        cx;
    logic [11:0]        cz;
    logic signed [23:0] nw;
    logic signed [23:0] ne;
    logic signed [23:0] sw;
    logic signed [23:0] se;
    logic signed [23:0] lvl;
    int                 n_segs;
  } cell_t;

  typedef struct {
    logic [35:0] sx;
    logic [35:0] sz;
    logic [35:0] ex;
    logic [35:0] ez;
    logic [24:0] hgt;
    logic        last;
  } seg_t;

  typedef struct {
    longint unsigned x;
    longint unsigned z;
  } gpt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [11:0] cell_x_i = '0;
  logic [11:0] cell_z_i = '0;
  logic signed [23:0] height_nw_i = '0;
  logic signed [23:0] height_ne_i = '0;
  logic signed [23:0] height_sw_i = '0;
  logic signed [23:0] height_se_i = '0;
  logic signed [23:0] contour_level_i = '0;
  logic seg_valid_o;
  logic [35:0] start_x_o, start_z_o, end_x_o, end_z_o;
  logic signed [24:0] segment_height_o;
  logic last_segment_o;

  contour_cell_segment_extract_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy,
    .cell_x_i, .cell_z_i, .height_nw_i, .height_ne_i, .height_sw_i,
    .height_se_i, .contour_level_i, .seg_valid_o, .start_x_o, .start_z_o,
    .end_x_o, .end_z_o, .segment_height_o, .last_segment_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  longint unsigned tile_size;
  longint height_offset;
  seg_t pending_segs[$];
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 0;

  function automatic bit edge_crossing(longint lvl, longint ha, longint hb,
                                       output longint unsigned t);
    longint da, db, den, num;
    longint unsigned n, d, q;
    da = ha - lvl;
    db = hb - lvl;
    den = hb - ha;
    num = lvl - ha;
    t = 0;
    if (da == 0 && db == 0) return 0;
    if ((da > 0 && db > 0) || (da < 0 && db < 0)) return 0;
    if (den == 0) return 0;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((n << FRAC) + d / 2) / d;
    if (q > ONE) q = ONE;
    t = q;
    return 1;
  endfunction

  function automatic longint unsigned adiff(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic seg_t make_seg(gpt_t a, gpt_t b, longint hgt, bit last);
    seg_t s;
    s.sx = (a.x * tile_size) & COORD_MASK;
    s.sz = (a.z * tile_size) & COORD_MASK;
    s.ex = (b.x * tile_size) & COORD_MASK;
    s.ez = (b.z * tile_size) & COORD_MASK;
    s.hgt = hgt[24:0];
    s.last = last;
    return s;
  endfunction

  // contour crossings of one cell, paired into segments
  function automatic int cell_segments(cell_t c, output seg_t segs[2]);
    longint nw, ne, sw, se, lvl, lo, hi, hgt;
    longint unsigned x0, z0, x1, z1, t, best, dx, dz, dd;
    gpt_t raw[4], pts[4];
    int nraw, npts, a0, a1, r0, r1;
    bit dup;
    nw = c.nw; ne = c.ne; sw = c.sw; se = c.se; lvl = c.lvl;
    nraw = 0; npts = 0;
    segs[0] = '{default: '0};
    segs[1] = '{default: '0};
    lo = nw; hi = nw;
    if (ne < lo) lo = ne;
    if (ne > hi) hi = ne;
    if (sw < lo) lo = sw;
    if (sw > hi) hi = sw;
    if (se < lo) lo = se;
    if (se > hi) hi = se;
    if (lvl < lo || lvl > hi) return 0;
    x0 = longint'(c.cx) << FRAC;
    z0 = longint'(c.cz) << FRAC;
    x1 = x0 + ONE;
    z1 = z0 + ONE;
    if (edge_crossing(lvl, nw, ne, t)) begin
      raw[nraw] = '{x0 + t, z0}; nraw++;
    end
    if (edge_crossing(lvl, ne, se, t)) begin
      raw[nraw] = '{x1, z0 + t}; nraw++;
    end
    if (edge_crossing(lvl, se, sw, t)) begin
      raw[nraw] = '{x1 - t, z1}; nraw++;
    end
    if (edge_crossing(lvl, sw, nw, t)) begin
      raw[nraw] = '{x0, z1 - t}; nraw++;
    end
    for (int i = 0; i < nraw; i++) begin
      dup = 0;
      for (int j = 0; j < npts; j++)
        if (adiff(pts[j].x, raw[i].x) <= DUP_LSB && adiff(pts[j].z, raw[i].z) <= DUP_LSB)
          dup = 1;
      if (!dup) begin
        pts[npts] = raw[i]; npts++;
      end
    end
    hgt = lvl + height_offset;
    if (npts == 2) begin
      segs[0] = make_seg(pts[0], pts[1], hgt, 1'b1);
      return 1;
    end
    if (npts == 4) begin
      best = '1; a0 = 0; a1 = 1; r0 = -1; r1 = -1;
      for (int i = 0; i < 4; i++)
        for (int j = i + 1; j < 4; j++) begin
          dx = adiff(pts[i].x, pts[j].x);
          dz = adiff(pts[i].z, pts[j].z);
          dd = dx * dx + dz * dz;
          if (dd < best) begin
            best = dd; a0 = i; a1 = j;
          end
        end
      for (int i = 0; i < 4; i++)
        if (i != a0 && i != a1) begin
          if (r0 < 0) r0 = i;
          else r1 = i;
        end
      segs[0] = make_seg(pts[a0], pts[a1], hgt, 1'b0);
      segs[1] = make_seg(pts[r0], pts[r1], hgt, 1'b1);
      return 2;
    end
    return 0;
  endfunction

  task automatic send_cell(cell_t c);
    seg_t segs[2];
    int n;
    if (!no_idle && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    cell_x_i <= c.cx;
    cell_z_i <= c.cz;
    height_nw_i <= c.nw;
    height_ne_i <= c.ne;
    height_sw_i <= c.sw;
    height_se_i <= c.se;
    contour_level_i <= c.lvl;
    do @(posedge clk_i); while (busy);
    n = cell_segments(c, segs);
    if (c.n_segs >= 0 && n != c.n_segs) begin
      errors++;
      $display("segment count of directed cell: expected %0d, predicted %0d", c.n_segs, n);
    end
    for (int i = 0; i < n; i++) pending_segs = {pending_segs, segs[i]};
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_TILE_SIZE) tile_size = val[7:0];
    else height_offset = longint'(signed'(val));
  endtask

  function automatic cell_t random_cell();
    cell_t c;
    int base, span;
    logic signed [23:0] lo, hi;
    c.cx = 12'($urandom_range(4095));
    c.cz = 12'($urandom_range(4095));
    c.n_segs = -1;
    if ($urandom_range(99) < 15) begin
      c.nw = 24'($urandom); c.ne = 24'($urandom); c.sw = 24'($urandom);
      c.se = 24'($urandom);
      c.lvl = 24'($urandom);
    end else begin
      span = ($urandom_range(3) == 0) ? 4000000 : $urandom_range(2000, 4);
      base = int'($urandom_range(16000000)) - 8000000;
      c.nw = 24'(base + int'($urandom_range(span)));
      c.ne = 24'(base + int'($urandom_range(span)));
      c.sw = 24'(base + int'($urandom_range(span)));
      c.se = 24'(base + int'($urandom_range(span)));
      lo = c.nw; hi = c.nw;
      if (c.ne < lo) lo = c.ne;
      if (c.ne > hi) hi = c.ne;
      if (c.sw < lo) lo = c.sw;
      if (c.sw > hi) hi = c.sw;
      if (c.se < lo) lo = c.se;
      if (c.se > hi) hi = c.se;
      case ($urandom_range(9))
        0: c.lvl = c.nw;
        1: c.lvl = hi + 24'sd1;
        default: c.lvl = 24'(int'(lo) + int'($urandom_range(int'(hi) - int'(lo))));
      endcase
    end
    return c;
  endfunction

  cell_t directed_cells[] = '{
    '{12'd0, 12'd0, 24'sd0, 24'sd256, 24'sd0, 24'sd256, 24'sd128, 1},
    '{12'd1, 12'd2, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd100, 0},
    '{12'd1, 12'd2, 24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd100, 0},
    '{12'd3, 12'd3, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 0},
    '{12'd5, 12'd6, 24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd128, 2},
    '{12'd7, 12'd8, 24'sd256, 24'sd0, 24'sd0, 24'sd300, 24'sd100, 2},
    '{12'd9, 12'd9, 24'sd0, 24'sd256, 24'sd256, 24'sd256, 24'sd0, 0},
    '{12'd4095, 12'd4095, -24'sd8388608, 24'sd8388607, -24'sd8388608,
      24'sd8388607, 24'sd0, 1},
    '{12'd4095, 12'd0, 24'sd8388607, -24'sd8388608, -24'sd8388608,
      -24'sd8388608, 24'sd8388607, 0},
    '{12'd0, 12'd4095, 24'sd0, 24'sd100000, 24'sd100000, 24'sd100000, 24'sd1, 0},
    '{12'd2730, 12'd1365, 24'sd0, 24'sd100000, 24'sd0, 24'sd0, 24'sd1, 1},
    '{12'd1365, 12'd2730, -24'sd8388608, 24'sd8388607, 24'sd8388607,
      -24'sd8388608, -24'sd8388608, 1},
    '{12'd100, 12'd200, 24'sd1000, 24'sd0, 24'sd0, 24'sd1000, 24'sd500, 2},
    '{12'd10, 12'd10, 24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd256, 1}
  };

  always @(posedge clk_i) begin
    seg_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_ni && seg_valid_o) begin
      if (pending_segs.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment at cycle %0d", cycles);
      end else begin
        want = pending_segs.pop_front();
        if (want.sx !== start_x_o || want.sz !== start_z_o || want.ex !== end_x_o ||
            want.ez !== end_z_o || want.hgt !== segment_height_o ||
            want.last !== last_segment_o) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("segment mismatch: expected %h %h %h %h %h %b, got %h %h %h %h %h %b",
                     want.sx, want.sz, want.ex, want.ez, want.hgt, want.last,
                     start_x_o, start_z_o, end_x_o, end_z_o, segment_height_o,
                     last_segment_o);
        end
      end
    end
  end

  initial begin
    tile_size = 16;
    height_offset = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_cells[i]) send_cell(directed_cells[i]);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_TILE_SIZE, 24'd255);
          write_reg(REG_HEIGHT_OFFSET, 24'h7FFFFF);
        end
        1: begin
          write_reg(REG_TILE_SIZE, 24'd1);
          write_reg(REG_HEIGHT_OFFSET, 24'h800000);
        end
        2: begin
          write_reg(REG_TILE_SIZE, 24'd0);
          write_reg(REG_HEIGHT_OFFSET, 24'h000100);
        end
        default: begin
          write_reg(REG_TILE_SIZE, 24'($urandom_range(255, 1)));
          write_reg(REG_HEIGHT_OFFSET, 24'($urandom));
        end
      endcase
      no_idle = (phase == 3);
      for (int i = 0; i < 265; i++) begin
        send_cell(random_cell());
        if (phase == 4 && i == 130) drain();
      end
      drain();
    end
    if (errors == 0 && pending_segs.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/ccse_pkg.sv
design/ccse_div.sv
design/ccse_front.sv
design/ccse_queue.sv
design/ccse_back.sv
design/contour_cell_segment_extract_core.sv
dv/contour_cell_segment_extract_core_tb.sv
